// File: design/nam_pkg.sv
// nam_pkg: shared types, field widths and codes of the nibble allocation map.
// Used by nam_ctrl, nam_dp and the top level nibble_allocation_map.
package nam_pkg;

    localparam int ADDR_W          = 16;
    localparam int SIZE_W          = 11;
    localparam int OWN_W           = 4;
    localparam int CMD_W           = 2;
    localparam int MAP_ENTRIES_DEF = 1024;

    // map entry codes
    localparam logic [OWN_W-1:0] ENT_FREE = 4'h0;
    localparam logic [OWN_W-1:0] ENT_CONT = 4'hF;

    // request commands
    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ALL   = 2'd3;

    // configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b1;

    // datapath operations issued by the controller
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_CLR  = 4'd1;
    localparam logic [OP_W-1:0] OP_LOAD = 4'd2;
    localparam logic [OP_W-1:0] OP_MARK = 4'd3;
    localparam logic [OP_W-1:0] OP_DN   = 4'd4;
    localparam logic [OP_W-1:0] OP_EVAL = 4'd5;
    localparam logic [OP_W-1:0] OP_UP   = 4'd6;
    localparam logic [OP_W-1:0] OP_FREE = 4'd7;
    localparam logic [OP_W-1:0] OP_ALL  = 4'd8;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [OWN_W-1:0]  owner;
    } nam_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] chunk_start;
        logic [SIZE_W-1:0] chunk_size;
        logic [OWN_W-1:0]  chunk_owner;
        logic              freed;
    } nam_res_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } nam_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             clr_last;
        logic             in_range;
        logic             owner_ok;
        logic             size_ok;
        logic             bound_zero;
        logic             mark_last;
        logic             dn_stop;
        logic             ent_ok;
        logic             up_stop;
        logic             free_hit;
        logic             free_last;
        logic             all_stop;
    } nam_stat_t;

endpackage

// File: design/nam_ram.sv
// nam_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module nam_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/nam_ctrl.sv
// nam_ctrl: controller state machine of the nibble allocation map.
// Depends on nam_pkg; drives nam_dp through nam_cmd_t, reads nam_stat_t.
module nam_ctrl
    import nam_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  nam_stat_t stat,
    output nam_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SEL  = 4'd2;
    localparam logic [3:0] S_MARK = 4'd3;
    localparam logic [3:0] S_DN   = 4'd4;
    localparam logic [3:0] S_EVAL = 4'd5;
    localparam logic [3:0] S_UP   = 4'd6;
    localparam logic [3:0] S_FREE = 4'd7;
    localparam logic [3:0] S_ALL  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                unique case (stat.cmd)
                    CMD_MARK:
                        state_next = (stat.in_range && stat.size_ok && stat.owner_ok) ?
                                     S_MARK : S_DONE;
                    CMD_FREE, CMD_QUERY:
                        state_next = stat.in_range ? S_DN : S_DONE;
                    CMD_ALL:
                        state_next = (stat.owner_ok && !stat.bound_zero) ? S_ALL : S_DONE;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_MARK:
            begin
                cmd.op = OP_MARK;
                if (stat.mark_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DN:
            begin
                cmd.op = OP_DN;
                if (stat.dn_stop)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.op     = OP_EVAL;
                state_next = stat.ent_ok ? S_UP : S_DONE;
            end
            S_UP:
            begin
                cmd.op = OP_UP;
                if (stat.up_stop)
                begin
                    state_next = stat.free_hit ? S_FREE : S_DONE;
                end
            end
            S_FREE:
            begin
                cmd.op = OP_FREE;
                if (stat.free_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_ALL:
            begin
                cmd.op = OP_ALL;
                if (stat.all_stop)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ($past(done) || $past(state_reg == S_CLR)))
        else $error("block went idle without delivering a result");

    a_eval_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> ($past(state_reg) == S_DN))
        else $error("head evaluation reached without a backward walk");

endmodule

// File: design/nam_dp.sv
// nam_dp: datapath of the nibble allocation map: config registers, map memory,
// walk pointers and result registers. Depends on nam_pkg and nam_ram.
module nam_dp
    import nam_pkg::*;
#(
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nam_cmd_t              cmd,
    input  nam_req_t              req,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output nam_stat_t             stat,
    output nam_res_t              res
);

    localparam int IDX_W = $clog2(MAP_ENTRIES);
    localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
    localparam int BW    = ADDR_W + 1;
    localparam logic [BW-1:0]    MAP_LIM   = BW'(MAP_ENTRIES);
    localparam logic [CNT_W-1:0] CLR_LAST  = CNT_W'(MAP_ENTRIES - 1);

    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] usize_reg;

    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  chk_reg, chk_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [OWN_W-1:0]  ent_reg, ent_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic              owned_reg, owned_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [OWN_W-1:0]  owner_reg, owner_next;
    logic              in_range_reg, in_range_next;
    nam_res_t          res_reg, res_next;

    logic [BW-1:0]     usize_ext;
    logic [BW-1:0]     bound_w;
    logic [CNT_W-1:0]  bound;
    logic [ADDR_W-1:0] idx;
    logic [BW-1:0]     idx_w;
    logic              owner_ok;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [OWN_W-1:0]  wr_data;
    logic              rd_en;
    logic [OWN_W-1:0]  rd_data;
    logic              hit;

    // walk bound is min(heap size, map depth)
    assign usize_ext = BW'(usize_reg);
    assign bound_w   = (usize_ext < MAP_LIM) ? usize_ext : MAP_LIM;
    assign bound     = bound_w[CNT_W-1:0];
    assign idx       = req.addr - base_reg;
    assign idx_w     = BW'(idx);
    assign owner_ok  = (owner_reg != ENT_FREE) && (owner_reg != ENT_CONT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            usize_reg   <= SIZE_W'(MAP_ENTRIES_DEF);
            ptr_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_BASE: base_reg  <= cfg_data;
                    CFG_SIZE: usize_reg <= cfg_data[SIZE_W-1:0];
                    default:  base_reg  <= base_reg;
                endcase
            end
            ptr_reg     <= ptr_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg      <= chk_next;
        head_reg     <= head_next;
        ent_reg      <= ent_next;
        cnt_reg      <= cnt_next;
        owned_reg    <= owned_next;
        cmd_reg      <= cmd_next;
        size_reg     <= size_next;
        owner_reg    <= owner_next;
        in_range_reg <= in_range_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        ptr_next      = ptr_reg;
        chk_next      = chk_reg;
        chk_vld_next  = chk_vld_reg;
        head_next     = head_reg;
        ent_next      = ent_reg;
        cnt_next      = cnt_reg;
        owned_next    = owned_reg;
        cmd_next      = cmd_reg;
        size_next     = size_reg;
        owner_next    = owner_reg;
        in_range_next = in_range_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg[IDX_W-1:0];
        wr_data       = ENT_FREE;
        rd_en         = 1'b0;
        hit           = 1'b0;
        unique case (cmd.op)
            OP_CLR:
            begin
                wr_en    = 1'b1;
                ptr_next = CNT_W'(ptr_reg + 1'b1);
            end
            OP_LOAD:
            begin
                cmd_next      = req.cmd;
                size_next     = req.size;
                owner_next    = req.owner;
                in_range_next = (idx_w < bound_w);
                ptr_next      = (req.cmd == CMD_ALL) ? '0 : idx_w[CNT_W-1:0];
                chk_vld_next  = 1'b0;
                cnt_next      = '0;
                owned_next    = 1'b0;
                res_next.chunk_start = (req.cmd == CMD_ALL) ? base_reg : req.addr;
                res_next.chunk_size  = '0;
                res_next.chunk_owner = ENT_FREE;
                res_next.freed       = 1'b0;
            end
            OP_MARK:
            begin
                wr_en    = 1'b1;
                wr_data  = (res_reg.chunk_size == '0) ? owner_reg : ENT_CONT;
                ptr_next = CNT_W'(ptr_reg + 1'b1);
                res_next.chunk_size  = SIZE_W'(res_reg.chunk_size + 1'b1);
                res_next.chunk_owner = owner_reg;
            end
            OP_DN:
            begin
                // read ahead one entry per cycle; the data checked lags by one
                rd_en        = 1'b1;
                chk_next     = ptr_reg;
                chk_vld_next = 1'b1;
                if (ptr_reg != '0)
                begin
                    ptr_next = CNT_W'(ptr_reg - 1'b1);
                end
                if (stat.dn_stop)
                begin
                    head_next    = chk_reg[IDX_W-1:0];
                    ent_next     = rd_data;
                    ptr_next     = CNT_W'(chk_reg + 1'b1);
                    chk_vld_next = 1'b0;
                end
            end
            OP_EVAL:
            begin
                if (stat.ent_ok)
                begin
                    res_next.chunk_start = base_reg + ADDR_W'(head_reg);
                    res_next.chunk_owner = ent_reg;
                    res_next.chunk_size  = SIZE_W'(1);
                end
            end
            OP_UP:
            begin
                chk_next     = ptr_reg;
                chk_vld_next = (ptr_reg < bound);
                if (ptr_reg < bound)
                begin
                    rd_en    = 1'b1;
                    ptr_next = CNT_W'(ptr_reg + 1'b1);
                end
                if (chk_vld_reg && (rd_data == ENT_CONT))
                begin
                    res_next.chunk_size = SIZE_W'(res_reg.chunk_size + 1'b1);
                end
                if (stat.up_stop)
                begin
                    ptr_next     = CNT_W'(head_reg);
                    chk_vld_next = 1'b0;
                end
            end
            OP_FREE:
            begin
                wr_en          = 1'b1;
                ptr_next       = CNT_W'(ptr_reg + 1'b1);
                cnt_next       = SIZE_W'(cnt_reg + 1'b1);
                res_next.freed = 1'b1;
            end
            OP_ALL:
            begin
                chk_next     = ptr_reg;
                chk_vld_next = (ptr_reg < bound);
                if (ptr_reg < bound)
                begin
                    rd_en    = 1'b1;
                    ptr_next = CNT_W'(ptr_reg + 1'b1);
                end
                if (chk_vld_reg)
                begin
                    // a continuation run belongs to the owner only behind a matching head
                    hit        = (rd_data == owner_reg) || ((rd_data == ENT_CONT) && owned_reg);
                    owned_next = hit;
                    if (hit)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = chk_reg[IDX_W-1:0];
                        res_next.freed = 1'b1;
                    end
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.clr_last   = (ptr_reg == CLR_LAST);
        stat.in_range   = in_range_reg;
        stat.owner_ok   = owner_ok;
        stat.size_ok    = (size_reg != '0);
        stat.bound_zero = (bound == '0);
        stat.mark_last  = (SIZE_W'(res_reg.chunk_size + 1'b1) == size_reg)
                          || (CNT_W'(ptr_reg + 1'b1) == bound);
        stat.dn_stop    = chk_vld_reg && ((rd_data != ENT_CONT) || (chk_reg == '0));
        stat.ent_ok     = (ent_reg != ENT_FREE) && (ent_reg != ENT_CONT);
        stat.up_stop    = (chk_vld_reg && (rd_data != ENT_CONT)) || (ptr_reg == bound);
        stat.free_hit   = (cmd_reg == CMD_FREE) && owner_ok && (ent_reg == owner_reg);
        stat.free_last  = (SIZE_W'(cnt_reg + 1'b1) == res_reg.chunk_size);
        stat.all_stop   = chk_vld_reg && (ptr_reg == bound);
    end

    assign res = res_reg;

    nam_ram #(
        .WIDTH (OWN_W),
        .DEPTH (MAP_ENTRIES)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    a_mark_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MARK) |-> (ptr_reg < bound))
        else $error("mark writes past the heap bound");

    a_up_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_UP) |-> (ptr_reg <= bound))
        else $error("forward walk pointer beyond the heap bound");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (ptr_reg[IDX_W-1:0] != wr_addr))
        else $error("map read and write hit the same entry in one cycle");

endmodule

// File: design/nibble_allocation_map.sv
// nibble_allocation_map: top level, heap allocation map with one 4-bit entry per heap byte.
// Depends on nam_pkg, nam_ctrl, nam_dp (which holds nam_ram).
//
// A request is taken when start is high and busy is low; its single result appears on
// result for one cycle with done high and must be captured then, as the receiver cannot
// stall. After reset the block sweeps the map to free, one entry per cycle, and stays
// busy until the whole map is cleared. Every request then runs through the map memory,
// one entry per cycle: mark writes up to size entries; query walks back from the address
// to the chunk head, then forward over the chunk; free then also clears the chunk when
// its owner matches; free-all walks bound entries, bound being min(heap size, MAP_ENTRIES).
// Configuration writes are accepted at any time but must only be issued while idle.
module nibble_allocation_map
    import nam_pkg::*;
#(
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  nam_req_t              req,
    output logic                  done,
    output nam_res_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    nam_cmd_t  cmd;
    nam_stat_t stat;

    assign cfg_ready = 1'b1;

    nam_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    nam_dp #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .res       (result)
    );

endmodule
